// ----- hdl/dsg_pkg.sv -----
// ----------------------------------------------------------------------------
// dsg_pkg
// shared constants, seed table and beat types for the double sqrt core
// ----------------------------------------------------------------------------
package dsg_pkg;

  localparam logic [63:0] EXP_MASK  = 64'h7ff0000000000000;
  localparam logic [63:0] SIGN_BIT  = 64'h8000000000000000;
  localparam logic [63:0] FRAC_MASK = 64'h000fffffffffffff;
  localparam logic [63:0] QNAN_BITS = 64'h7ff8000000000000;
  localparam logic [31:0] THREE_2_30 = 32'hc0000000;
  localparam logic [10:0] EXP_BIAS = 11'h3ff;

  // pass-through kinds for special operands
  typedef enum logic [1:0] {
    KIND_NORMAL,
    KIND_PASS,
    KIND_NAN
  } kind_t;

  // side information carried along the pipeline
  typedef struct packed {
    kind_t       kind;
    logic [63:0] pass_bits;
    logic [10:0] res_exp;
  } side_t;

  function automatic logic [15:0] seed_lookup(input logic [6:0] idx);
    logic [15:0] v;
    case (idx)
      7'd0: v = 16'hb451; 7'd1: v = 16'hb2f0; 7'd2: v = 16'hb196; 7'd3: v = 16'hb044;
      7'd4: v = 16'haef9; 7'd5: v = 16'hadb6; 7'd6: v = 16'hac79; 7'd7: v = 16'hab43;
      7'd8: v = 16'haa14; 7'd9: v = 16'ha8eb; 7'd10: v = 16'ha7c8; 7'd11: v = 16'ha6aa;
      7'd12: v = 16'ha592; 7'd13: v = 16'ha480; 7'd14: v = 16'ha373; 7'd15: v = 16'ha26b;
      7'd16: v = 16'ha168; 7'd17: v = 16'ha06a; 7'd18: v = 16'h9f70; 7'd19: v = 16'h9e7b;
      7'd20: v = 16'h9d8a; 7'd21: v = 16'h9c9d; 7'd22: v = 16'h9bb5; 7'd23: v = 16'h9ad1;
      7'd24: v = 16'h99f0; 7'd25: v = 16'h9913; 7'd26: v = 16'h983a; 7'd27: v = 16'h9765;
      7'd28: v = 16'h9693; 7'd29: v = 16'h95c4; 7'd30: v = 16'h94f8; 7'd31: v = 16'h9430;
      7'd32: v = 16'h936b; 7'd33: v = 16'h92a9; 7'd34: v = 16'h91ea; 7'd35: v = 16'h912e;
      7'd36: v = 16'h9075; 7'd37: v = 16'h8fbe; 7'd38: v = 16'h8f0a; 7'd39: v = 16'h8e59;
      7'd40: v = 16'h8daa; 7'd41: v = 16'h8cfe; 7'd42: v = 16'h8c54; 7'd43: v = 16'h8bac;
      7'd44: v = 16'h8b07; 7'd45: v = 16'h8a64; 7'd46: v = 16'h89c4; 7'd47: v = 16'h8925;
      7'd48: v = 16'h8889; 7'd49: v = 16'h87ee; 7'd50: v = 16'h8756; 7'd51: v = 16'h86c0;
      7'd52: v = 16'h862b; 7'd53: v = 16'h8599; 7'd54: v = 16'h8508; 7'd55: v = 16'h8479;
      7'd56: v = 16'h83ec; 7'd57: v = 16'h8361; 7'd58: v = 16'h82d8; 7'd59: v = 16'h8250;
      7'd60: v = 16'h81c9; 7'd61: v = 16'h8145; 7'd62: v = 16'h80c2; 7'd63: v = 16'h8040;
      7'd64: v = 16'hff02; 7'd65: v = 16'hfd0e; 7'd66: v = 16'hfb25; 7'd67: v = 16'hf947;
      7'd68: v = 16'hf773; 7'd69: v = 16'hf5aa; 7'd70: v = 16'hf3ea; 7'd71: v = 16'hf234;
      7'd72: v = 16'hf087; 7'd73: v = 16'heee3; 7'd74: v = 16'hed47; 7'd75: v = 16'hebb3;
      7'd76: v = 16'hea27; 7'd77: v = 16'he8a3; 7'd78: v = 16'he727; 7'd79: v = 16'he5b2;
      7'd80: v = 16'he443; 7'd81: v = 16'he2dc; 7'd82: v = 16'he17a; 7'd83: v = 16'he020;
      7'd84: v = 16'hdecb; 7'd85: v = 16'hdd7d; 7'd86: v = 16'hdc34; 7'd87: v = 16'hdaf1;
      7'd88: v = 16'hd9b3; 7'd89: v = 16'hd87b; 7'd90: v = 16'hd748; 7'd91: v = 16'hd61a;
      7'd92: v = 16'hd4f1; 7'd93: v = 16'hd3cd; 7'd94: v = 16'hd2ad; 7'd95: v = 16'hd192;
      7'd96: v = 16'hd07b; 7'd97: v = 16'hcf69; 7'd98: v = 16'hce5b; 7'd99: v = 16'hcd51;
      7'd100: v = 16'hcc4a; 7'd101: v = 16'hcb48; 7'd102: v = 16'hca4a; 7'd103: v = 16'hc94f;
      7'd104: v = 16'hc858; 7'd105: v = 16'hc764; 7'd106: v = 16'hc674; 7'd107: v = 16'hc587;
      7'd108: v = 16'hc49d; 7'd109: v = 16'hc3b7; 7'd110: v = 16'hc2d4; 7'd111: v = 16'hc1f4;
      7'd112: v = 16'hc116; 7'd113: v = 16'hc03c; 7'd114: v = 16'hbf65; 7'd115: v = 16'hbe90;
      7'd116: v = 16'hbdbe; 7'd117: v = 16'hbcef; 7'd118: v = 16'hbc23; 7'd119: v = 16'hbb59;
      7'd120: v = 16'hba91; 7'd121: v = 16'hb9cc; 7'd122: v = 16'hb90a; 7'd123: v = 16'hb84a;
      7'd124: v = 16'hb78c; 7'd125: v = 16'hb6d0; 7'd126: v = 16'hb617; 7'd127: v = 16'hb560;
      default: v = 16'hb451;
    endcase
    return v;
  endfunction

endpackage

// ----- hdl/dsg_unpack.sv -----
// ----------------------------------------------------------------------------
// dsg_unpack
// classifies the operand, normalises subnormals and forms the significand
// ----------------------------------------------------------------------------
module dsg_unpack (
  input  logic               clk,
  input  logic               en,
  input  logic [63:0]        operand_bits,
  output logic [63:0]        m,
  output logic [6:0]         idx,
  output dsg_pkg::side_t     side
);

  logic [10:0] top;
  logic [51:0] frac;
  logic [5:0]  p;
  logic        found;
  logic [63:0] ix;
  logic [11:0] top_n;
  logic [63:0] m_c;
  dsg_pkg::side_t side_c;
  logic [11:0] ex;

  always_comb begin
    top = operand_bits[62:52];
    frac = operand_bits[51:0];
    p = 6'd0;
    found = 1'b0;
    for (int i = 51; i >= 0; i--) begin
      if (!found && frac[i]) begin
        p = 6'(i);
        found = 1'b1;
      end
    end
    side_c.kind = dsg_pkg::KIND_NORMAL;
    side_c.pass_bits = operand_bits;
    ix = operand_bits;
    top_n = {operand_bits[63], top};
    if (operand_bits[62:0] == 63'd0 || operand_bits == dsg_pkg::EXP_MASK) begin
      side_c.kind = dsg_pkg::KIND_PASS;
    end else if (operand_bits > dsg_pkg::EXP_MASK) begin
      side_c.kind = dsg_pkg::KIND_NAN;
      side_c.pass_bits = dsg_pkg::QNAN_BITS;
    end else if (top == 11'd0) begin
      ix = ({12'd0, frac} << (7'd52 - {1'b0, p})) & dsg_pkg::FRAC_MASK;
      ix[63:52] = {6'd0, p + 6'd1};
      top_n = {6'd0, p + 6'd1} - 12'd52;
    end
    m_c = {1'b1, ix[51:0], 11'd0};
    if (top_n[0]) m_c = m_c >> 1;
    ex = top_n + {1'b0, dsg_pkg::EXP_BIAS};
    side_c.res_exp = ex[11:1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m <= m_c;
      idx <= ix[52:46];
      side <= side_c;
    end
  end

endmodule

// ----- hdl/dsg_mul32_step.sv -----
// ----------------------------------------------------------------------------
// dsg_mul32_step
// one registered 32x32 high-half product
// ----------------------------------------------------------------------------
module dsg_mul32_step (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] p
);

  logic [63:0] prod;

  assign prod = {32'd0, a} * {32'd0, b};

  always_ff @(posedge clk) begin
    if (en) p <= prod[63:32];
  end

endmodule

// ----- hdl/dsg_core.sv -----
// ----------------------------------------------------------------------------
// dsg_core
// goldschmidt refinement and rounding, one multiply level per stage
// ----------------------------------------------------------------------------
module dsg_core (
  input  logic            clk,
  input  logic            en,
  input  logic [63:0]     m_in,
  input  logic [6:0]      idx_in,
  input  dsg_pkg::side_t  side_in,
  output logic [63:0]     result,
  output logic            bad
);

  logic [15:0] seed;

  // stage registers, numbered by stage
  logic [63:0] m0, m1, m2, m3, m4;
  dsg_pkg::side_t sd0, sd1, sd2, sd3, sd4, sd5, sd6;
  dsg_pkg::side_t sd7, sd8, sd9, sd10, sd11, sd12, sd13;
  logic [31:0] r0, s0, r1, s1, u1, r3, u3, r5, r6;
  logic [31:0] pr2, ps2, pr4;
  logic [31:0] r2, s2, r4;
  logic [21:0] mlo5, mlo6, mlo7, mlo8, mlo9, mlo10, mlo11;
  logic [63:0] w5, v5, x6, x7, w7, v7, x8, u8, h9, l9, x10, x11, q11, x12, d12;
  logic [51:0] x13;

  logic [63:0] pd1, pd3, pv5, pl7, phl9, plh9, ll11, cr11, dd;

  assign seed = dsg_pkg::seed_lookup(idx_in);

  // stage 0: s = m*r with the seed
  dsg_mul32_step u_s0 (.clk(clk), .en(en), .a(m_in[63:32]), .b({seed, 16'd0}), .p(s0));
  // stage 2: r and s update
  dsg_mul32_step u_r2 (.clk(clk), .en(en), .a(r1), .b(u1), .p(pr2));
  dsg_mul32_step u_s2 (.clk(clk), .en(en), .a(s1), .b(u1), .p(ps2));
  // stage 4: r update
  dsg_mul32_step u_r4 (.clk(clk), .en(en), .a(r3), .b(u3), .p(pr4));

  assign r2 = {pr2[30:0], 1'b0};
  assign s2 = {ps2[30:0], 1'b0};
  assign r4 = {pr4[30:0], 1'b0};

  assign pd1  = {32'd0, s0} * {32'd0, r0};
  assign pd3  = {32'd0, s2} * {32'd0, r2};
  assign pv5  = {32'd0, m4[31:0]} * {32'd0, r4};
  assign pl7  = {32'd0, x6[31:0]} * {32'd0, r6};
  assign phl9 = {32'd0, x8[63:32]} * {32'd0, u8[31:0]};
  assign plh9 = {32'd0, x8[31:0]} * {32'd0, u8[63:32]};
  // s fits in 55 bits; low 64 bits of s*s from 32-bit partials
  assign ll11 = {32'd0, x10[31:0]} * {32'd0, x10[31:0]};
  assign cr11 = {32'd0, x10[63:32]} * {32'd0, x10[31:0]};
  assign dd   = x12 - d12;

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 0
      m0 <= m_in;
      sd0 <= side_in;
      r0 <= {seed, 16'd0};
      // stage 1: d = s*r, u = 3/2 - d
      m1 <= m0;
      sd1 <= sd0;
      r1 <= r0;
      s1 <= s0;
      u1 <= dsg_pkg::THREE_2_30 - pd1[63:32];
      // stage 2
      m2 <= m1;
      sd2 <= sd1;
      // stage 3: d = s*r, u
      m3 <= m2;
      sd3 <= sd2;
      r3 <= r2;
      u3 <= dsg_pkg::THREE_2_30 - pd3[63:32];
      // stage 4
      m4 <= m3;
      sd4 <= sd3;
      // stage 5: s = hi_mul64(m, r<<32) partials
      sd5 <= sd4;
      mlo5 <= m4[21:0];
      r5 <= r4;
      w5 <= {32'd0, m4[63:32]} * {32'd0, r4};
      v5 <= {32'd0, pv5[63:32]};
      // stage 6: sum
      sd6 <= sd5;
      mlo6 <= mlo5;
      r6 <= r5;
      x6 <= w5 + v5;
      // stage 7: d partials
      sd7 <= sd6;
      mlo7 <= mlo6;
      x7 <= x6;
      w7 <= {32'd0, x6[63:32]} * {32'd0, r6};
      v7 <= {32'd0, pl7[63:32]};
      // stage 8: d, u
      sd8 <= sd7;
      mlo8 <= mlo7;
      x8 <= x7;
      u8 <= {dsg_pkg::THREE_2_30, 32'd0} - (w7 + v7);
      // stage 9: s*u partials
      sd9 <= sd8;
      mlo9 <= mlo8;
      h9 <= {32'd0, x8[63:32]} * {32'd0, u8[63:32]};
      l9 <= {32'd0, phl9[63:32]} + {32'd0, plh9[63:32]};
      // stage 10: s sum and shift
      sd10 <= sd9;
      mlo10 <= mlo9;
      x10 <= (h9 + l9 - 64'd2) >> 9;
      // stage 11: square
      sd11 <= sd10;
      mlo11 <= mlo10;
      x11 <= x10;
      q11 <= ll11 + {cr11[30:0], 33'd0};
      // stage 12: d0
      sd12 <= sd11;
      x12 <= x11;
      d12 <= {mlo11, 42'd0} - q11;
      // stage 13: round
      sd13 <= sd12;
      x13 <= x12[51:0] + {51'd0, dd[63]};
    end
  end

  always_comb begin
    bad = sd13.kind == dsg_pkg::KIND_NAN;
    case (sd13.kind)
      dsg_pkg::KIND_NORMAL: result = {1'b0, sd13.res_exp, x13};
      default: result = sd13.pass_bits;
    endcase
  end

endmodule

// ----- hdl/double_sqrt_goldschmidt_core.sv -----
// ----------------------------------------------------------------------------
// double_sqrt_goldschmidt_core
// pipelined binary64 square root, round to nearest
// ----------------------------------------------------------------------------
// Takes one operand beat per cycle while the output is not stalled and returns
// one result beat per operand, in order; each operand passes the unpack register,
// the core stage registers and the output register. The depth is set by the chain of
// 32-bit multiplies in the goldschmidt refinement, one multiply level per
// stage. While a result beat waits on the output the whole pipeline freezes
// and the input is held off.
module double_sqrt_goldschmidt_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // operand_bits
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // root_bits
  output logic        m_tuser    // invalid
);

  localparam int unsigned LAT = 16;

  logic [LAT-1:0] vld;
  logic           en;
  logic [63:0]    m;
  logic [6:0]     idx;
  dsg_pkg::side_t side;
  logic [63:0]    result;
  logic           bad;

  assign en = m_tready || !vld[LAT-1];
  assign s_tready = en && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  dsg_unpack u_unpack (
    .clk(clk), .en(en), .operand_bits(s_tdata), .m(m), .idx(idx), .side(side)
  );

  dsg_core u_core (
    .clk(clk), .en(en), .m_in(m), .idx_in(idx), .side_in(side),
    .result(result), .bad(bad)
  );

  logic [63:0] out_q;
  logic        bad_q;
  always_ff @(posedge clk) begin
    if (en) begin
      out_q <= result;
      bad_q <= bad;
    end
  end

  assign m_tvalid = vld[LAT-1];
  assign m_tdata = out_q;
  assign m_tuser = bad_q;

endmodule
